FILE: rtl/lpm_pkg.sv
// Types, constants and helpers shared by the IPv4 longest-prefix-match route table.
`default_nettype none
package lpm_pkg;

	localparam int TABLE_ENTRIES_DEF = 64;
	localparam int ADDR_W            = 32;
	localparam int LEN_W             = 6;
	localparam int INDEX_W           = 6;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ADDR_W);

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} lpm_op_t;

	typedef struct packed {
		lpm_op_t            operation;
		logic [INDEX_W-1:0] entry_index;
		logic               entry_valid;
		logic               entry_usable;
		logic [ADDR_W-1:0]  entry_prefix;
		logic [LEN_W-1:0]   entry_prefix_len;
		logic               entry_has_gateway;
		logic [ADDR_W-1:0]  entry_gateway;
		logic [ADDR_W-1:0]  lookup_address;
	} lpm_in_t;

	typedef struct packed {
		logic              found;
		logic [ADDR_W-1:0] next_gateway;
		logic [LEN_W-1:0]  matched_length;
	} lpm_out_t;

	typedef struct packed {
		logic             valid;
		logic             usable;
		logic             has_gw;
		logic [LEN_W-1:0] len;
	} lpm_flags_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_RESULT
	} lpm_state_t;

	function automatic logic [ADDR_W-1:0] lpm_prefix_mask(input logic [LEN_W-1:0] len);
		logic [ADDR_W-1:0] m;
		if (len == '0) begin
			m = '0;
		end else if (len >= LEN_MAX) begin
			m = '1;
		end else begin
			m = {ADDR_W{1'b1}} << (LEN_MAX - len);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/ipv4_longest_prefix_match.sv
// IPv4 longest-prefix-match route table with a sequential linear scan.
//
//   channel  | signals                       | payload
//   ---------+-------------------------------+----------------------------
//   input    | in_valid / in_ready           | in_data  (lpm_pkg::lpm_in_t)
//   output   | out_valid / out_ready         | out_data (lpm_pkg::lpm_out_t)
//
// A table write returns an all-zero result.
// A lookup makes one memory read and one prefix compare per entry through a
// single compare unit, then passes through drain and result.
// After reset a clearing pass zeroes the flag memory entry by entry;
// in_ready stays low until it ends.
// in_ready is low while a lookup scans, drains or holds its result, and while a result waits and out_ready is low.
`default_nettype none
module ipv4_longest_prefix_match #(
	parameter int TABLE_ENTRIES = lpm_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire lpm_pkg::lpm_in_t in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output lpm_pkg::lpm_out_t     out_data
);
	import lpm_pkg::*;

	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);

	lpm_flags_t        flags_mem  [TABLE_ENTRIES];
	logic [ADDR_W-1:0] prefix_mem [TABLE_ENTRIES];
	logic [ADDR_W-1:0] gw_mem     [TABLE_ENTRIES];

	lpm_state_t        state_q, state_nxt;
	logic [AW-1:0]     scan_idx_q;
	logic              scan_last;

	logic              in_xfer, wr_xfer, lk_xfer, wr_in_range;
	logic              out_free;
	logic              clear_we, scan_step, rd_en, load_result;

	logic              flags_we;
	logic [AW-1:0]     flags_waddr;
	lpm_flags_t        flags_wdata;
	logic [LEN_W-1:0]  sat_len;

	logic              rd_valid_s1;
	lpm_flags_t        rd_flags_s1;
	logic [ADDR_W-1:0] rd_prefix_s1;
	logic [ADDR_W-1:0] rd_gw_s1;

	logic [ADDR_W-1:0] dst_q;
	logic              hit_q;
	logic [LEN_W-1:0]  best_len_q;
	logic [ADDR_W-1:0] best_gw_q;
	logic              take;

	logic              out_valid_q;
	lpm_out_t          out_data_q;

	assign out_free    = !out_valid_q || out_ready;
	assign in_xfer     = in_valid && in_ready;
	assign wr_xfer     = in_xfer && (in_data.operation == OP_WRITE);
	assign lk_xfer     = in_xfer && (in_data.operation == OP_LOOKUP);
	assign wr_in_range = 32'(in_data.entry_index) < 32'(TABLE_ENTRIES);
	assign scan_last   = (scan_idx_q == LAST_IDX);

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR:  if (scan_last) state_nxt = ST_IDLE;
			ST_IDLE:   if (lk_xfer) state_nxt = ST_SCAN;
			ST_SCAN:   if (scan_last) state_nxt = ST_DRAIN;
			ST_DRAIN:  state_nxt = ST_RESULT;
			ST_RESULT: if (out_free) state_nxt = ST_IDLE;
			default:   state_nxt = ST_CLEAR;
		endcase
	end

	always_comb begin
		in_ready    = 1'b0;
		clear_we    = 1'b0;
		scan_step   = 1'b0;
		rd_en       = 1'b0;
		load_result = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				clear_we  = 1'b1;
				scan_step = 1'b1;
			end
			ST_IDLE:   in_ready = out_free;
			ST_SCAN: begin
				rd_en     = 1'b1;
				scan_step = 1'b1;
			end
			ST_DRAIN:  ;
			ST_RESULT: load_result = out_free;
			default:   ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			scan_idx_q  <= '0;
			rd_valid_s1 <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			rd_valid_s1 <= rd_en;
			if (scan_step) begin
				scan_idx_q <= scan_last ? '0 : scan_idx_q + AW'(1);
			end
			if (lk_xfer) begin
				hit_q <= 1'b0;
			end else if (take) begin
				hit_q <= 1'b1;
			end
			if (wr_xfer || load_result) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// flag memory write port, shared with the clearing pass
	assign sat_len = (in_data.entry_prefix_len > LEN_MAX) ? LEN_MAX : in_data.entry_prefix_len;

	always_comb begin
		flags_we    = 1'b0;
		flags_waddr = scan_idx_q;
		flags_wdata = '0;
		if (clear_we) begin
			flags_we = 1'b1;
		end else if (wr_xfer && wr_in_range) begin
			flags_we    = 1'b1;
			flags_waddr = AW'(in_data.entry_index);
			flags_wdata = '{valid:  in_data.entry_valid,
			                usable: in_data.entry_usable,
			                has_gw: in_data.entry_has_gateway,
			                len:    sat_len};
		end
	end

	always_ff @(posedge clk) begin
		if (flags_we) begin
			flags_mem[flags_waddr] <= flags_wdata;
		end
		if (rd_en) begin
			rd_flags_s1 <= flags_mem[scan_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_xfer && wr_in_range) begin
			prefix_mem[AW'(in_data.entry_index)] <= in_data.entry_prefix;
			gw_mem[AW'(in_data.entry_index)]     <= in_data.entry_gateway;
		end
		if (rd_en) begin
			rd_prefix_s1 <= prefix_mem[scan_idx_q];
			rd_gw_s1     <= gw_mem[scan_idx_q];
		end
	end

	// shared compare unit: one entry per cycle
	assign take = rd_valid_s1 && rd_flags_s1.valid && rd_flags_s1.usable
	           && (!hit_q || (rd_flags_s1.len > best_len_q))
	           && ((dst_q & lpm_prefix_mask(rd_flags_s1.len)) == rd_prefix_s1);

	always_ff @(posedge clk) begin
		if (lk_xfer) begin
			dst_q <= in_data.lookup_address;
		end
		if (take) begin
			best_len_q <= rd_flags_s1.len;
			best_gw_q  <= rd_flags_s1.has_gw ? rd_gw_s1 : '0;
		end
		if (wr_xfer) begin
			out_data_q <= '0;
		end else if (load_result) begin
			out_data_q.found          <= hit_q;
			out_data_q.next_gateway   <= hit_q ? best_gw_q : '0;
			out_data_q.matched_length <= hit_q ? best_len_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
`default_nettype wire

FILE: rtl/lpm_checker.sv
// Port-level checks for the route table, bound to the top level.
`default_nettype none
module lpm_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire lpm_pkg::lpm_in_t  in_data,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire lpm_pkg::lpm_out_t out_data
);
	import lpm_pkg::*;

	// never take an input while an untaken result would be overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> (!out_valid || out_ready))
		else $error("input ready while result blocked");

	// busy after a lookup transfer
	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && (in_data.operation == OP_LOOKUP)) |=> !in_ready)
		else $error("ready right after lookup transfer");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_data.found) |->
			(out_data.next_gateway == '0 && out_data.matched_length == '0))
		else $error("miss result carries data");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.matched_length <= LEN_MAX))
		else $error("matched length out of range");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
		else $error("stalled result changed");

endmodule

bind ipv4_longest_prefix_match lpm_checker u_lpm_checker (.*);
`default_nettype wire
